>>> hw/rtl/sha256_message_hash_unit_macros.svh
// assertion macros for the sha-256 message hash unit checker
`ifndef SHA256_MESSAGE_HASH_UNIT_MACROS_SVH
`define SHA256_MESSAGE_HASH_UNIT_MACROS_SVH

// same-cycle implication, sampled on clk_i, off while rst_ni is low
`define SMH_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk_i, off while rst_ni is low
`define SMH_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hw/rtl/smh_pkg.sv
// shared constants, tables and control struct of the sha-256 hash unit
`default_nettype none

package smh_pkg;

  localparam int unsigned DigestWords = 8;
  localparam int unsigned Rounds      = 64;

  localparam logic [7:0]  PadByte  = 8'h80;
  localparam logic [63:0] ByteBits = 64'd8;

  localparam logic [31:0] InitHash [DigestWords] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [31:0] RoundK [Rounds] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  typedef struct packed {
    logic shift_byte;  // push one byte into the block register
    logic roll;        // advance the message schedule by one word
    logic init;        // copy the chain value into the working variables
    logic round;       // run one compression round
    logic fold;        // add the working variables into the chain value
    logic restart;     // reload the initial hash for the next message
  } ctrl_t;

  function automatic logic [31:0] rotr(input logic [31:0] x, input logic [4:0] n);
    rotr = (x >> n) | (x << (6'd32 - {1'b0, n}));
  endfunction

endpackage

`default_nettype wire

>>> hw/rtl/smh_sched.sv
// block register: byte-wise fill and rolling 16-word message schedule
`default_nettype none

module smh_sched (
  input  wire logic          clk_i,
  input  wire smh_pkg::ctrl_t ctrl_i,
  input  wire logic [7:0]    byte_i,
  output logic [31:0]        word_o
);

  logic [511:0] blk_q, blk_d;
  logic [31:0]  w0, w1, w9, w14, s0, s1, next_word;

  assign w0  = blk_q[511:480];
  assign w1  = blk_q[479:448];
  assign w9  = blk_q[223:192];
  assign w14 = blk_q[63:32];

  assign s0 = smh_pkg::rotr(w1, 5'd7) ^ smh_pkg::rotr(w1, 5'd18) ^ (w1 >> 3);
  assign s1 = smh_pkg::rotr(w14, 5'd17) ^ smh_pkg::rotr(w14, 5'd19) ^ (w14 >> 10);
  assign next_word = s1 + w9 + s0 + w0;

  assign word_o = w0;

  always_comb begin
    blk_d = blk_q;
    if (ctrl_i.shift_byte) begin
      blk_d = {blk_q[503:0], byte_i};
    end else if (ctrl_i.roll) begin
      blk_d = {blk_q[479:0], next_word};
    end
  end

  always_ff @(posedge clk_i) begin
    blk_q <= blk_d;
  end

endmodule

`default_nettype wire

>>> hw/rtl/smh_round.sv
// working variables, shared round unit and chain value
`default_nettype none

module smh_round (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire smh_pkg::ctrl_t ctrl_i,
  input  wire logic [31:0]    w_i,
  input  wire logic [5:0]     round_i,
  input  wire logic [2:0]     sel_i,
  output logic [31:0]         digest_o
);

  logic [31:0] work_q  [smh_pkg::DigestWords];
  logic [31:0] work_d  [smh_pkg::DigestWords];
  logic [31:0] chain_q [smh_pkg::DigestWords];
  logic [31:0] chain_d [smh_pkg::DigestWords];
  logic [31:0] a, b, c, d, e, f, g, h;
  logic [31:0] big_s0, big_s1, ch, maj, t1, t2;

  assign a = work_q[0];
  assign b = work_q[1];
  assign c = work_q[2];
  assign d = work_q[3];
  assign e = work_q[4];
  assign f = work_q[5];
  assign g = work_q[6];
  assign h = work_q[7];

  assign big_s1 = smh_pkg::rotr(e, 5'd6) ^ smh_pkg::rotr(e, 5'd11) ^ smh_pkg::rotr(e, 5'd25);
  assign big_s0 = smh_pkg::rotr(a, 5'd2) ^ smh_pkg::rotr(a, 5'd13) ^ smh_pkg::rotr(a, 5'd22);
  assign ch     = (e & f) ^ (~e & g);
  assign maj    = (a & b) ^ (a & c) ^ (b & c);
  assign t1     = h + big_s1 + ch + smh_pkg::RoundK[round_i] + w_i;
  assign t2     = big_s0 + maj;

  assign digest_o = chain_q[sel_i];

  always_comb begin
    work_d  = work_q;
    chain_d = chain_q;
    if (ctrl_i.init) begin
      work_d = chain_q;
    end else if (ctrl_i.round) begin
      work_d[0] = t1 + t2;
      work_d[1] = a;
      work_d[2] = b;
      work_d[3] = c;
      work_d[4] = d + t1;
      work_d[5] = e;
      work_d[6] = f;
      work_d[7] = g;
    end
    if (ctrl_i.fold) begin
      for (int i = 0; i < smh_pkg::DigestWords; i++) begin
        chain_d[i] = chain_q[i] + work_q[i];
      end
    end else if (ctrl_i.restart) begin
      chain_d = smh_pkg::InitHash;
    end
  end

  always_ff @(posedge clk_i) begin
    work_q <= work_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chain_q <= smh_pkg::InitHash;
    end else begin
      chain_q <= chain_d;
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/sha256_message_hash_unit.sv
// sha-256 message hash unit: byte intake, padding sequencer and digest output
//
// input channel: one beat carries message_byte_i with byte_present_i and
// end_of_message_i; a beat with the end flag closes the message (with or
// without a byte), a beat with neither flag does nothing.
// output channel: after a closing beat, eight beats carry the digest words,
// word_index_o 0 first, last_word_o on the eighth.
// sequence: a beat that completes a 64-byte block holds in_ready_o low
// through load, 64 rounds of the single shared round unit and chain add.
// closing runs the padding bytes through the same byte path one per cycle
// (with one extra compression when fewer than 9 bytes are left in the
// block), then the final compression, then the eight words.
// in_ready_o is high only while the unit waits for input; a stalled receiver
// simply holds the current digest word until out_ready_i rises.
// reset loads the initial hash, clears the byte count and returns to idle.
`default_nettype none

module sha256_message_hash_unit (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [7:0]  message_byte_i,
  input  wire logic        byte_present_i,
  input  wire logic        end_of_message_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [31:0]      digest_word_o,
  output logic [2:0]       word_index_o,
  output logic             last_word_o
);

  localparam logic [2:0] StIdle  = 3'd0;
  localparam logic [2:0] StPad   = 3'd1;
  localparam logic [2:0] StLen   = 3'd2;
  localparam logic [2:0] StInit  = 3'd3;
  localparam logic [2:0] StRound = 3'd4;
  localparam logic [2:0] StFold  = 3'd5;
  localparam logic [2:0] StOut   = 3'd6;

  localparam logic [5:0] LastFill  = 6'd63;
  localparam logic [5:0] PadEnd    = 6'd55;
  localparam logic [5:0] LastRound = 6'(smh_pkg::Rounds - 1);
  localparam logic [2:0] LastWord  = 3'(smh_pkg::DigestWords - 1);

  logic [2:0]  state_q, state_d;
  logic [5:0]  fill_q, fill_d;
  logic [5:0]  cnt_q, cnt_d;
  logic [63:0] bits_q, bits_d;
  logic        closing_q, closing_d;
  logic        pad_first_q, pad_first_d;
  logic        final_q, final_d;
  logic [7:0]  byte_in;
  logic [31:0] sched_word;
  logic        in_fire;
  smh_pkg::ctrl_t ctrl;

  assign in_ready_o = (state_q == StIdle);
  assign in_fire    = in_valid_i & in_ready_o;

  always_comb begin
    state_d     = state_q;
    fill_d      = fill_q;
    cnt_d       = cnt_q;
    bits_d      = bits_q;
    closing_d   = closing_q;
    pad_first_d = pad_first_q;
    final_d     = final_q;
    byte_in     = message_byte_i;
    ctrl        = '0;
    out_valid_o = 1'b0;
    case (state_q)
      StIdle: begin
        if (in_fire) begin
          if (byte_present_i) begin
            ctrl.shift_byte = 1'b1;
            fill_d = fill_q + 6'd1;
            bits_d = bits_q + smh_pkg::ByteBits;
          end
          if (end_of_message_i) begin
            closing_d   = 1'b1;
            pad_first_d = 1'b1;
          end
          if (byte_present_i && fill_q == LastFill) begin
            state_d = StInit;
          end else if (end_of_message_i) begin
            state_d = StPad;
          end
        end
      end
      StPad: begin
        ctrl.shift_byte = 1'b1;
        byte_in     = pad_first_q ? smh_pkg::PadByte : 8'h00;
        pad_first_d = 1'b0;
        fill_d      = fill_q + 6'd1;
        if (fill_q == LastFill) begin
          state_d = StInit;
        end else if (fill_q == PadEnd) begin
          state_d = StLen;
        end
      end
      StLen: begin
        // bit length goes out msb first and leaves the counter at zero
        ctrl.shift_byte = 1'b1;
        byte_in = bits_q[63:56];
        bits_d  = {bits_q[55:0], 8'h00};
        fill_d  = fill_q + 6'd1;
        if (fill_q == LastFill) begin
          final_d = 1'b1;
          state_d = StInit;
        end
      end
      StInit: begin
        ctrl.init = 1'b1;
        cnt_d     = '0;
        state_d   = StRound;
      end
      StRound: begin
        ctrl.round = 1'b1;
        ctrl.roll  = 1'b1;
        cnt_d      = cnt_q + 6'd1;
        if (cnt_q == LastRound) begin
          state_d = StFold;
        end
      end
      StFold: begin
        ctrl.fold = 1'b1;
        cnt_d     = '0;
        if (final_q) begin
          state_d = StOut;
        end else if (closing_q) begin
          state_d = StPad;
        end else begin
          state_d = StIdle;
        end
      end
      StOut: begin
        out_valid_o = 1'b1;
        if (out_ready_i) begin
          cnt_d = cnt_q + 6'd1;
          if (cnt_q[2:0] == LastWord) begin
            ctrl.restart = 1'b1;
            closing_d    = 1'b0;
            final_d      = 1'b0;
            cnt_d        = '0;
            state_d      = StIdle;
          end
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      fill_q      <= '0;
      cnt_q       <= '0;
      bits_q      <= '0;
      closing_q   <= 1'b0;
      pad_first_q <= 1'b0;
      final_q     <= 1'b0;
    end else begin
      state_q     <= state_d;
      fill_q      <= fill_d;
      cnt_q       <= cnt_d;
      bits_q      <= bits_d;
      closing_q   <= closing_d;
      pad_first_q <= pad_first_d;
      final_q     <= final_d;
    end
  end

  smh_sched u_sched (
    .clk_i  (clk_i),
    .ctrl_i (ctrl),
    .byte_i (byte_in),
    .word_o (sched_word)
  );

  smh_round u_round (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctrl_i   (ctrl),
    .w_i      (sched_word),
    .round_i  (cnt_q),
    .sel_i    (cnt_q[2:0]),
    .digest_o (digest_word_o)
  );

  assign word_index_o = cnt_q[2:0];
  assign last_word_o  = (cnt_q[2:0] == LastWord);

endmodule

`default_nettype wire

>>> hw/rtl/smh_checker.sv
// port-level checker for the sha-256 message hash unit, bound to the top level
`default_nettype none

`include "sha256_message_hash_unit_macros.svh"

module smh_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        in_valid_i,
  input wire logic        in_ready_i,
  input wire logic        end_of_message_i,
  input wire logic        out_valid_i,
  input wire logic        out_ready_i,
  input wire logic [2:0]  word_index_i,
  input wire logic        last_word_i
);

  logic out_fire;

  assign out_fire = out_valid_i & out_ready_i;

  `SMH_ASSERT_NOW(a_last_on_final, out_valid_i, last_word_i == (word_index_i == 3'd7), "last_word flag does not match word index")
  `SMH_ASSERT_NOW(a_no_intake_during_output, out_valid_i, !in_ready_i, "input taken while digest is being delivered")
  `SMH_ASSERT_NEXT(a_index_steps, out_fire && !last_word_i, out_valid_i && word_index_i == $past(word_index_i) + 3'd1, "digest words out of order")
  `SMH_ASSERT_NEXT(a_done_after_last, out_fire && last_word_i, !out_valid_i && in_ready_i, "unit not back to idle after last digest beat")
  `SMH_ASSERT_NEXT(a_busy_after_close, in_valid_i && in_ready_i && end_of_message_i, !in_ready_i, "input accepted right after a closing beat")

endmodule

bind sha256_message_hash_unit smh_checker u_smh_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .in_valid_i       (in_valid_i),
  .in_ready_i       (in_ready_o),
  .end_of_message_i (end_of_message_i),
  .out_valid_i      (out_valid_o),
  .out_ready_i      (out_ready_i),
  .word_index_i     (word_index_o),
  .last_word_i      (last_word_o)
);

`default_nettype wire
